### sv/laml_pkg.sv
// shared constants and types for the look-at matrix builder
`default_nettype none

package laml_pkg;

  // fraction bits of the internal unit vectors
  localparam int FRAC       = 30;
  localparam int UW         = FRAC + 2;
  localparam int VW         = 64;
  localparam int FIT_W      = 30;
  localparam int FIT_TOP    = FIT_W - 1;
  localparam int SQRT_STEPS = VW / 2;
  localparam int LEN_W      = SQRT_STEPS;
  localparam int DIV_STEPS  = FRAC + 1;
  localparam int Q16_SHIFT  = FRAC - 16;
  localparam int DOT_W      = 66;
  localparam int ROWS       = 4;

  localparam logic [1:0]        LAST_ROW = 2'd3;
  localparam logic signed [31:0] ONE_Q16 = 32'sd65536;

  typedef logic signed [VW-1:0] wide_t;
  typedef wide_t [2:0]          wvec_t;
  typedef logic signed [UW-1:0] unit_t;
  typedef unit_t [2:0]          uvec_t;
  typedef logic signed [31:0]   word_t;
  typedef word_t [2:0]          cvec_t;

  // values that ride along the pipeline next to the vector being worked on
  typedef struct packed {
    cvec_t cam;
    cvec_t up;
    uvec_t view;
    uvec_t side;
    logic  degen;
  } carry_t;

endpackage

`default_nettype wire

### sv/laml_fit.sv
// two-stage block scaling of a vector so its largest magnitude sits in [2^29, 2^30)
`default_nettype none

module laml_fit (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  laml_pkg::wvec_t                     vec_i,
  output logic [2:0][laml_pkg::FIT_W-1:0]     mag_o,
  output logic [2:0]                          neg_o,
  output logic                                zero_o
);
  import laml_pkg::*;

  localparam int PW = $clog2(VW);

  logic [2:0][VW-1:0]    abs_d, abs_q;
  logic [2:0]            neg_d, neg_q, neg2_q;
  logic [VW-1:0]         all_or;
  logic [PW-1:0]         msb_d, msb_q;
  logic                  zero_d, zero_q, zero2_q;
  logic [2:0][FIT_W-1:0] fit_d, fit_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = vec_i[i][VW-1];
      abs_d[i] = neg_d[i] ? VW'(-vec_i[i]) : VW'(vec_i[i]);
    end
    // msb of the largest magnitude equals msb of the or of all of them
    all_or = abs_d[0] | abs_d[1] | abs_d[2];
    zero_d = (all_or == '0);
    msb_d  = '0;
    for (int b = 0; b < VW; b++) begin
      if (all_or[b]) msb_d = PW'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      abs_q  <= abs_d;
      neg_q  <= neg_d;
      msb_q  <= msb_d;
      zero_q <= zero_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (msb_q >= PW'(FIT_TOP)) begin
        fit_d[i] = FIT_W'(abs_q[i] >> (msb_q - PW'(FIT_TOP)));
      end else begin
        fit_d[i] = FIT_W'(abs_q[i] << (PW'(FIT_TOP) - msb_q));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fit_q   <= fit_d;
      neg2_q  <= neg_q;
      zero2_q <= zero_q;
    end
  end

  assign mag_o  = fit_q;
  assign neg_o  = neg2_q;
  assign zero_o = zero2_q;

endmodule

`default_nettype wire

### sv/laml_norm.sv
// pipelined normalize: fit, sum of squares, square root and restoring divide
`default_nettype none

module laml_norm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  laml_pkg::wvec_t  vec_i,
  input  laml_pkg::carry_t carry_i,
  output logic             valid_o,
  output laml_pkg::uvec_t  unit_o,
  output logic             zero_o,
  output laml_pkg::carry_t carry_o
);
  import laml_pkg::*;

  localparam int SQ_W = 2 * FIT_W;
  localparam int RW   = LEN_W + 1;
  localparam int QW   = FRAC + 1;

  logic [2:0][FIT_W-1:0] fit_mag;
  logic [2:0]            fit_neg;
  logic                  fit_zero;

  logic [1:0] fv_q;
  carry_t     fc_q [2];

  logic                  sqv_q;
  carry_t                sqc_q;
  logic [2:0][FIT_W-1:0] sqm_q;
  logic [2:0]            sqn_q;
  logic                  sqz_q;
  logic [2:0][SQ_W-1:0]  sqp_q;

  logic                  rv_q   [SQRT_STEPS+1];
  carry_t                rc_q   [SQRT_STEPS+1];
  logic [2:0][FIT_W-1:0] rm_q   [SQRT_STEPS+1];
  logic [2:0]            rn_q   [SQRT_STEPS+1];
  logic                  rz_q   [SQRT_STEPS+1];
  logic [VW-1:0]         rnum_q [SQRT_STEPS+1];
  logic [VW-1:0]         rres_q [SQRT_STEPS+1];

  logic                  dv_q   [DIV_STEPS+1];
  carry_t                dc_q   [DIV_STEPS+1];
  logic [2:0]            dn_q   [DIV_STEPS+1];
  logic                  dz_q   [DIV_STEPS+1];
  logic [LEN_W-1:0]      dlen_q [DIV_STEPS+1];
  logic [2:0][RW-1:0]    drem_q [DIV_STEPS+1];
  logic [2:0][QW-1:0]    dquo_q [DIV_STEPS+1];

  laml_fit u_fit (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .vec_i  (vec_i),
    .mag_o  (fit_mag),
    .neg_o  (fit_neg),
    .zero_o (fit_zero)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q  <= '0;
      sqv_q <= 1'b0;
      rv_q[0] <= 1'b0;
      dv_q[0] <= 1'b0;
    end else if (en_i) begin
      fv_q  <= {fv_q[0], valid_i};
      sqv_q <= fv_q[1];
      rv_q[0] <= sqv_q;
      dv_q[0] <= rv_q[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fc_q[0] <= carry_i;
      fc_q[1] <= fc_q[0];
      sqc_q   <= fc_q[1];
      sqm_q   <= fit_mag;
      sqn_q   <= fit_neg;
      sqz_q   <= fit_zero;
      for (int i = 0; i < 3; i++) begin
        sqp_q[i] <= SQ_W'(fit_mag[i]) * SQ_W'(fit_mag[i]);
      end
      rc_q[0]   <= sqc_q;
      rm_q[0]   <= sqm_q;
      rn_q[0]   <= sqn_q;
      rz_q[0]   <= sqz_q;
      rnum_q[0] <= VW'(sqp_q[0]) + VW'(sqp_q[1]) + VW'(sqp_q[2]);
      rres_q[0] <= '0;
      // divider setup from the finished root
      dc_q[0]   <= rc_q[SQRT_STEPS];
      dn_q[0]   <= rn_q[SQRT_STEPS];
      dz_q[0]   <= rz_q[SQRT_STEPS];
      dlen_q[0] <= rres_q[SQRT_STEPS][LEN_W-1:0];
      for (int i = 0; i < 3; i++) begin
        drem_q[0][i] <= RW'(rm_q[SQRT_STEPS][i]);
      end
      dquo_q[0] <= '0;
    end
  end

  // one root digit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [VW-1:0] bitv, trial, num_d, res_d;

    always_comb begin
      bitv  = VW'(1) << (VW - 2 - 2 * k);
      trial = rres_q[k] + bitv;
      if (rnum_q[k] >= trial) begin
        num_d = rnum_q[k] - trial;
        res_d = (rres_q[k] >> 1) + bitv;
      end else begin
        num_d = rnum_q[k];
        res_d = rres_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rv_q[k+1] <= 1'b0;
      end else if (en_i) begin
        rv_q[k+1] <= rv_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rc_q[k+1]   <= rc_q[k];
        rm_q[k+1]   <= rm_q[k];
        rn_q[k+1]   <= rn_q[k];
        rz_q[k+1]   <= rz_q[k];
        rnum_q[k+1] <= num_d;
        rres_q[k+1] <= res_d;
      end
    end
  end

  // one quotient bit per stage, three lanes side by side
  for (genvar d = 0; d < DIV_STEPS; d++) begin : g_div
    logic [2:0][RW-1:0] rsh, rem_d;
    logic [2:0][QW-1:0] qsh, quo_d;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        rsh[i] = (d == 0) ? drem_q[d][i] : RW'(drem_q[d][i] << 1);
        qsh[i] = (d == 0) ? dquo_q[d][i] : QW'(dquo_q[d][i] << 1);
        if (rsh[i] >= RW'(dlen_q[d])) begin
          rem_d[i] = rsh[i] - RW'(dlen_q[d]);
          quo_d[i] = qsh[i] | QW'(1);
        end else begin
          rem_d[i] = rsh[i];
          quo_d[i] = qsh[i];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[d+1] <= 1'b0;
      end else if (en_i) begin
        dv_q[d+1] <= dv_q[d];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dc_q[d+1]   <= dc_q[d];
        dn_q[d+1]   <= dn_q[d];
        dz_q[d+1]   <= dz_q[d];
        dlen_q[d+1] <= dlen_q[d];
        drem_q[d+1] <= rem_d;
        dquo_q[d+1] <= quo_d;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dz_q[DIV_STEPS]) begin
        unit_o[i] = '0;
      end else if (dn_q[DIV_STEPS][i]) begin
        unit_o[i] = -UW'(dquo_q[DIV_STEPS][i]);
      end else begin
        unit_o[i] = UW'(dquo_q[DIV_STEPS][i]);
      end
    end
  end

  assign valid_o = dv_q[DIV_STEPS];
  assign zero_o  = dz_q[DIV_STEPS];
  assign carry_o = dc_q[DIV_STEPS];

endmodule

`default_nettype wire

### sv/laml_cross.sv
// pipelined cross product of two fitted vectors
`default_nettype none

module laml_cross (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  laml_pkg::wvec_t  a_i,
  input  laml_pkg::wvec_t  b_i,
  input  laml_pkg::carry_t carry_i,
  output logic             valid_o,
  output laml_pkg::wvec_t  vec_o,
  output laml_pkg::carry_t carry_o
);
  import laml_pkg::*;

  localparam int SW     = FIT_W + 1;
  localparam int PROD_W = 2 * SW;

  logic [2:0][FIT_W-1:0] a_mag, b_mag;
  logic [2:0]            a_neg, b_neg;
  logic                  a_zero, b_zero;

  logic [1:0] fv_q;
  carry_t     fc_q [2];

  logic signed [SW-1:0]     pa [3];
  logic signed [SW-1:0]     pb [3];
  logic signed [PROD_W-1:0] mp_d [6];
  logic signed [PROD_W-1:0] mp_q [6];
  logic                     mv_q, mz_q;
  carry_t                   mc_q;

  logic                     cv_q;
  wvec_t                    c_d, c_q;
  carry_t                   cc_q;

  laml_fit u_fit_a (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .vec_i  (a_i),
    .mag_o  (a_mag),
    .neg_o  (a_neg),
    .zero_o (a_zero)
  );

  laml_fit u_fit_b (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .vec_i  (b_i),
    .mag_o  (b_mag),
    .neg_o  (b_neg),
    .zero_o (b_zero)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa[i] = a_neg[i] ? -$signed({1'b0, a_mag[i]}) : $signed({1'b0, a_mag[i]});
      pb[i] = b_neg[i] ? -$signed({1'b0, b_mag[i]}) : $signed({1'b0, b_mag[i]});
    end
    mp_d[0] = pa[1] * pb[2];
    mp_d[1] = pa[2] * pb[1];
    mp_d[2] = pa[2] * pb[0];
    mp_d[3] = pa[0] * pb[2];
    mp_d[4] = pa[0] * pb[1];
    mp_d[5] = pa[1] * pb[0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_d[i] = mz_q ? '0 : VW'(mp_q[2*i]) - VW'(mp_q[2*i+1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= '0;
      mv_q <= 1'b0;
      cv_q <= 1'b0;
    end else if (en_i) begin
      fv_q <= {fv_q[0], valid_i};
      mv_q <= fv_q[1];
      cv_q <= mv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fc_q[0] <= carry_i;
      fc_q[1] <= fc_q[0];
      mc_q    <= fc_q[1];
      mz_q    <= a_zero | b_zero;
      mp_q    <= mp_d;
      cc_q    <= mc_q;
      c_q     <= c_d;
    end
  end

  assign valid_o = cv_q;
  assign vec_o   = c_q;
  assign carry_o = cc_q;

endmodule

`default_nettype wire

### sv/look_at_matrix_builder.sv
// top level: look-at view matrix builder, four rows out per input beat
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o | camera_*_i, target_*_i, upward_*_i
//  out     | out_valid_o/out_ready_i | row_number_o, elem_0..3_o, last_row_o,
//          |                         | degenerate_o
//
// one input beat per cycle enters the pipeline while in_ready_o is high; each
// item leaves as four output beats, so the single output port, one row per
// beat, sets the sustained rate. the first row becomes valid after the input register,
// three 68-stage normalizers, two 4-stage cross products, the dot stages and the row buffer.
// the whole pipeline holds while the row buffer is busy and its last stage
// is full; reset clears only the valid bits and the row counter.
`default_nettype none

module look_at_matrix_builder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] camera_x_i,
  input  logic signed [31:0] camera_y_i,
  input  logic signed [31:0] camera_z_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic signed [31:0] upward_x_i,
  input  logic signed [31:0] upward_y_i,
  input  logic signed [31:0] upward_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         row_number_o,
  output logic signed [31:0] elem_0_o,
  output logic signed [31:0] elem_1_o,
  output logic signed [31:0] elem_2_o,
  output logic signed [31:0] elem_3_o,
  output logic               last_row_o,
  output logic               degenerate_o
);
  import laml_pkg::*;

  localparam logic [DOT_W-1:0] POS_MAX = DOT_W'(32'h7FFF_FFFF);
  localparam logic [DOT_W-1:0] NEG_MAX = DOT_W'(33'h0_8000_0000);

  logic en, ob_free;

  // input register
  logic   v0_q;
  wvec_t  dir_d, dir_q;
  carry_t c0_d, c0_q;

  logic   v1, v2, v3, v4, v5;
  uvec_t  u1, u3, u5;
  logic   z1, z3, z5;
  carry_t c1, c1b, c2, c3, c3b, c4, c5;
  wvec_t  x2, x4, up_w, view_w, side_w;

  // dot product and entry stages
  uvec_t                 ax [3];
  logic signed [63:0]    prod_d [3][3];
  logic signed [63:0]    prod_q [3][3];
  logic [2:0][2:0][31:0] ent_d, ent_q, entb_q;
  logic                  va_q, vb_q, dga_q, dgb_q;
  logic signed [DOT_W-1:0] dot_d [3];
  logic signed [DOT_W-1:0] dot_q [3];

  // row buffer
  logic [ROWS-1:0][2:0][31:0] ob_d, ob_q;
  logic                       obv_q, obdg_q;
  logic [1:0]                 row_q;

  assign ob_free    = !obv_q || (out_ready_i && row_q == LAST_ROW);
  assign en         = ob_free || !vb_q;
  assign in_ready_o = en;

  always_comb begin
    c0_d          = '0;
    c0_d.cam[0]   = camera_x_i;
    c0_d.cam[1]   = camera_y_i;
    c0_d.cam[2]   = camera_z_i;
    c0_d.up[0]    = upward_x_i;
    c0_d.up[1]    = upward_y_i;
    c0_d.up[2]    = upward_z_i;
    dir_d[0] = VW'(target_x_i) - VW'(camera_x_i);
    dir_d[1] = VW'(target_y_i) - VW'(camera_y_i);
    dir_d[2] = VW'(target_z_i) - VW'(camera_z_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dir_q <= dir_d;
      c0_q  <= c0_d;
    end
  end

  laml_norm u_norm_view (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v0_q),
    .vec_i   (dir_q),
    .carry_i (c0_q),
    .valid_o (v1),
    .unit_o  (u1),
    .zero_o  (z1),
    .carry_o (c1)
  );

  // view axis points away from the target
  always_comb begin
    c1b       = c1;
    c1b.degen = z1;
    for (int i = 0; i < 3; i++) begin
      c1b.view[i] = -u1[i];
      up_w[i]     = VW'(c1.up[i]);
      view_w[i]   = VW'(c1b.view[i]);
    end
  end

  laml_cross u_cross_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1),
    .a_i     (up_w),
    .b_i     (view_w),
    .carry_i (c1b),
    .valid_o (v2),
    .vec_o   (x2),
    .carry_o (c2)
  );

  laml_norm u_norm_side (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2),
    .vec_i   (x2),
    .carry_i (c2),
    .valid_o (v3),
    .unit_o  (u3),
    .zero_o  (z3),
    .carry_o (c3)
  );

  always_comb begin
    c3b       = c3;
    c3b.side  = u3;
    c3b.degen = c3.degen | z3;
    for (int i = 0; i < 3; i++) begin
      side_w[i] = VW'(u3[i]);
    end
  end

  logic [2:0][VW-1:0] view3_w;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      view3_w[i] = VW'(c3.view[i]);
    end
  end

  laml_cross u_cross_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3),
    .a_i     (view3_w),
    .b_i     (side_w),
    .carry_i (c3b),
    .valid_o (v4),
    .vec_o   (x4),
    .carry_o (c4)
  );

  laml_norm u_norm_up (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v4),
    .vec_i   (x4),
    .carry_i (c4),
    .valid_o (v5),
    .unit_o  (u5),
    .zero_o  (z5),
    .carry_o (c5)
  );

  // columns: side, true up, view
  always_comb begin
    logic [UW-1:0] amag;
    logic [31:0]   sh;
    ax[0] = c5.side;
    ax[1] = u5;
    ax[2] = c5.view;
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        prod_d[j][i] = $signed(c5.cam[i]) * $signed(ax[j][i]);
      end
    end
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        amag = ax[j][r][UW-1] ? UW'(-ax[j][r]) : UW'(ax[j][r]);
        sh   = 32'(amag >> Q16_SHIFT);
        ent_d[r][j] = ax[j][r][UW-1] ? -sh : sh;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      dot_d[j] = -(DOT_W'(prod_q[j][0]) + DOT_W'(prod_q[j][1]) + DOT_W'(prod_q[j][2]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en) begin
      va_q <= v5;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= prod_d;
      ent_q  <= ent_d;
      dga_q  <= c5.degen;
      dot_q  <= dot_d;
      entb_q <= ent_q;
      dgb_q  <= dga_q;
    end
  end

  // rows 0..2 take the axis entries; translation row: truncate toward zero, then saturate; all zero when degenerate
  always_comb begin
    logic             dneg;
    logic [DOT_W-1:0] dmag, dsh;
    logic [31:0]      sat;
    for (int r = 0; r < 3; r++) begin
      ob_d[r] = dgb_q ? '0 : entb_q[r];
    end
    for (int j = 0; j < 3; j++) begin
      dneg = dot_q[j][DOT_W-1];
      dmag = dneg ? DOT_W'(-dot_q[j]) : DOT_W'(dot_q[j]);
      dsh  = dmag >> FRAC;
      if (dneg) begin
        sat = (dsh > NEG_MAX) ? 32'h8000_0000 : -dsh[31:0];
      end else begin
        sat = (dsh > POS_MAX) ? 32'h7FFF_FFFF : dsh[31:0];
      end
      ob_d[LAST_ROW][j] = dgb_q ? '0 : sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obv_q <= 1'b0;
      row_q <= '0;
    end else if (vb_q && ob_free) begin
      obv_q <= 1'b1;
      row_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      obv_q <= (row_q != LAST_ROW);
      row_q <= row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vb_q && ob_free) begin
      ob_q   <= ob_d;
      obdg_q <= dgb_q;
    end
  end

  assign out_valid_o  = obv_q;
  assign row_number_o = row_q;
  assign elem_0_o     = ob_q[row_q][0];
  assign elem_1_o     = ob_q[row_q][1];
  assign elem_2_o     = ob_q[row_q][2];
  assign elem_3_o     = (row_q == LAST_ROW) ? ONE_Q16 : '0;
  assign last_row_o   = (row_q == LAST_ROW);
  assign degenerate_o = obdg_q;

`ifndef SYNTH
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_row_o
      |=> out_valid_o && row_number_o == $past(row_number_o) + 2'd1)
    else $error("row sequence broken inside an item");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> elem_0_o == '0 && elem_1_o == '0 && elem_2_o == '0)
    else $error("degenerate item carries nonzero entries");

  a_up_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5 && !c5.degen |-> !z5)
    else $error("true up axis vanished for a valid side axis");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && vb_q)
    else $error("pipeline held without a busy row buffer");
`endif

endmodule

`default_nettype wire
